[hdl/txc_pkg.sv]
// ----------------------------------------------------------------------------
// txc_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package txc_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam logic [7:0] NEWLINE_CODE   = 8'h0A;
  localparam logic [7:0] SPACE_CODE     = 8'h20;
  localparam logic [7:0] RESET_ATTR     = 8'h07;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

[hdl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen writer with a cell memory, a cursor and scrolling.
//
// Channel   Direction  Payload
// s_axis    in         tuser: cmd; tdata: char_code[7:0], read_index[18:8]
// m_axis    out        tdata: read_data[15:0], cursor_row[20:16],
//                             cursor_col[27:21], scrolled[28]
// cfg       in         data: text_attribute[7:0]
//
// A character passes through the done state before its reply, and a read
// also through a read state for the memory read. A step past the last row
// scrolls the screen, copying one cell per cycle through the single memory
// port pair. After reset a clearing pass over every cell runs before the
// first request is taken. A held result is kept in the output register
// while the next request is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = txc_pkg::ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,   // cmd
  input  logic [23:0] s_axis_tdata,   // char_code, read_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // read_data, cursor_row, cursor_col, scrolled
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RWD        = $clog2(ROWS);
  localparam int CWD        = $clog2(COLUMNS);

  localparam logic [AW-1:0]  COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0]  LAST_CELL = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0]  COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [RWD-1:0] ROW_LAST  = RWD'(ROWS - 1);
  localparam logic [CWD-1:0] COL_LAST  = CWD'(COLUMNS - 1);

  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rdata;
  logic        we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0] wdata;

  txc_pkg::state_t state, state_next;
  logic [AW-1:0]  cnt, cnt_next;
  logic [RWD-1:0] row, row_next;
  logic [CWD-1:0] col, col_next;
  logic [AW-1:0]  row_base, row_base_next;
  logic [7:0]     attr;
  logic           pend_valid, pend_valid_next;
  logic [AW-1:0]  pend_addr, pend_addr_next;
  logic           pend_blank, pend_blank_next;
  logic           rd_ok, rd_ok_next;
  logic [15:0]    res_data, res_data_next;
  logic           res_scrolled, res_scrolled_next;
  logic           out_valid, out_valid_next;
  logic [15:0]    out_data, out_data_next;
  logic [4:0]     out_row, out_row_next;
  logic [6:0]     out_col, out_col_next;
  logic           out_scrolled, out_scrolled_next;

  logic        in_accept;
  logic        advance;
  logic [7:0]  char_code;
  logic [10:0] read_index;

  assign char_code     = s_axis_tdata[7:0];
  assign read_index    = s_axis_tdata[18:8];
  assign s_axis_tready = (state == txc_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_scrolled, out_col, out_row, out_data};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    row_next          = row;
    col_next          = col;
    row_base_next     = row_base;
    pend_valid_next   = 1'b0;
    pend_addr_next    = pend_addr;
    pend_blank_next   = pend_blank;
    rd_ok_next        = rd_ok;
    res_data_next     = res_data;
    res_scrolled_next = res_scrolled;
    out_valid_next    = out_valid & ~m_axis_tready;
    out_data_next     = out_data;
    out_row_next      = out_row;
    out_col_next      = out_col;
    out_scrolled_next = out_scrolled;
    advance           = 1'b0;
    raddr             = cnt + COLS_A;
    we                = pend_valid;
    waddr             = pend_addr;
    wdata             = pend_blank ? {attr, txc_pkg::SPACE_CODE} : rdata;

    unique case (state)
      txc_pkg::ST_CLEAR: begin
        we       = 1'b1;
        waddr    = cnt;
        wdata    = 16'h0000;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = txc_pkg::ST_IDLE;
        end
      end
      txc_pkg::ST_IDLE: begin
        raddr = AW'(read_index);
        if (in_accept) begin
          res_data_next     = 16'h0000;
          res_scrolled_next = 1'b0;
          if (s_axis_tuser == txc_pkg::CMD_READ) begin
            rd_ok_next = (32'(read_index) < 32'(CELL_COUNT));
            state_next = txc_pkg::ST_READ;
          end else begin
            state_next = txc_pkg::ST_DONE;
            if (char_code == txc_pkg::NEWLINE_CODE) begin
              advance = 1'b1;
            end else begin
              we    = 1'b1;
              waddr = row_base + AW'(col);
              wdata = {attr, char_code};
              if (col == COL_LAST) begin
                advance = 1'b1;
              end else begin
                col_next = col + 1'b1;
              end
            end
            if (advance) begin
              col_next = '0;
              if (row == ROW_LAST) begin
                res_scrolled_next = 1'b1;
                cnt_next          = '0;
                state_next        = txc_pkg::ST_COPY;
              end else begin
                row_next      = row + 1'b1;
                row_base_next = row_base + COLS_A;
              end
            end
          end
        end
      end
      txc_pkg::ST_READ: begin
        res_data_next = rd_ok ? rdata : 16'h0000;
        state_next    = txc_pkg::ST_DONE;
      end
      txc_pkg::ST_COPY: begin
        pend_valid_next = 1'b1;
        pend_addr_next  = cnt;
        pend_blank_next = 1'b0;
        cnt_next        = cnt + 1'b1;
        if (cnt == COPY_LAST) begin
          state_next = txc_pkg::ST_FILL;
        end
      end
      txc_pkg::ST_FILL: begin
        pend_valid_next = 1'b1;
        pend_addr_next  = cnt;
        pend_blank_next = 1'b1;
        cnt_next        = cnt + 1'b1;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = txc_pkg::ST_DONE;
        end
      end
      txc_pkg::ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next    = 1'b1;
          out_data_next     = res_data;
          out_row_next      = 5'(row);
          out_col_next      = 7'(col);
          out_scrolled_next = res_scrolled;
          state_next        = txc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = txc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= txc_pkg::ST_CLEAR;
      cnt        <= '0;
      row        <= '0;
      col        <= '0;
      row_base   <= '0;
      attr       <= txc_pkg::RESET_ATTR;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      row        <= row_next;
      col        <= col_next;
      row_base   <= row_base_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        attr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr    <= pend_addr_next;
    pend_blank   <= pend_blank_next;
    rd_ok        <= rd_ok_next;
    res_data     <= res_data_next;
    res_scrolled <= res_scrolled_next;
    out_data     <= out_data_next;
    out_row      <= out_row_next;
    out_col      <= out_col_next;
    out_scrolled <= out_scrolled_next;
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put-character and cell-read requests into the stream input and
// checks every reply against the typed directed entry or an in-bench model
// of the screen and cursor. A short table of directed requests comes first.
// Random phases follow, each with its own attribute byte, and both stream sides
// idle at random. One long receiver hold-off fills the block up so that it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int COLUMNS        = txc_pkg::COLUMNS_DEFAULT;
  localparam int ROWS           = txc_pkg::ROWS_DEFAULT;
  localparam int CELL_COUNT     = ROWS * COLUMNS;
  localparam int PHASE_COUNT    = 5;
  localparam int PHASE_REQUESTS = 290;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 50;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic       RD = txc_pkg::CMD_READ;
  localparam logic       WR = txc_pkg::CMD_WRITE;
  localparam logic [7:0] NL = txc_pkg::NEWLINE_CODE;

  typedef struct packed {
    logic        scrolled;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [15:0] data;
  } console_reply_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  code;
    logic [10:0] index;
    logic [7:0]  repeats;
    logic        typed;
    logic [15:0] data;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } stimulus_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam stimulus_row_t DIRECTED[DIRECTED_ROWS] = '{
    '{RD, 8'h00, 11'd0,    8'd1,  1'b1, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{RD, 8'h00, 11'd1999, 8'd1,  1'b1, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{RD, 8'h00, 11'd2000, 8'd1,  1'b1, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{RD, 8'hFF, 11'd2047, 8'd1,  1'b1, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{WR, 8'h41, 11'd0,    8'd1,  1'b1, 16'h0000, 5'd0,  7'd1,  1'b0},
    '{WR, 8'h0D, 11'd0,    8'd1,  1'b1, 16'h0000, 5'd0,  7'd2,  1'b0},
    '{WR, 8'h00, 11'd0,    8'd1,  1'b1, 16'h0000, 5'd0,  7'd3,  1'b0},
    '{WR, 8'hFF, 11'd2047, 8'd1,  1'b1, 16'h0000, 5'd0,  7'd4,  1'b0},
    '{RD, 8'h00, 11'd0,    8'd1,  1'b1, 16'h0741, 5'd0,  7'd4,  1'b0},
    '{RD, 8'h00, 11'd1,    8'd1,  1'b1, 16'h070D, 5'd0,  7'd4,  1'b0},
    '{RD, 8'h00, 11'd2,    8'd1,  1'b1, 16'h0700, 5'd0,  7'd4,  1'b0},
    '{RD, 8'h00, 11'd3,    8'd1,  1'b1, 16'h07FF, 5'd0,  7'd4,  1'b0},
    '{WR, NL,    11'd0,    8'd1,  1'b1, 16'h0000, 5'd1,  7'd0,  1'b0},
    '{WR, 8'h77, 11'd0,    8'd79, 1'b0, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{WR, 8'h7A, 11'd0,    8'd1,  1'b1, 16'h0000, 5'd2,  7'd0,  1'b0},
    '{WR, NL,    11'd0,    8'd22, 1'b0, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{WR, 8'h71, 11'd0,    8'd79, 1'b0, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{WR, 8'h71, 11'd0,    8'd1,  1'b1, 16'h0000, 5'd24, 7'd0,  1'b1},
    '{WR, NL,    11'd0,    8'd1,  1'b1, 16'h0000, 5'd24, 7'd0,  1'b1},
    '{RD, 8'h00, 11'd1920, 8'd1,  1'b1, 16'h0720, 5'd24, 7'd0,  1'b0},
    '{RD, 8'h00, 11'd1999, 8'd1,  1'b1, 16'h0720, 5'd24, 7'd0,  1'b0},
    '{RD, 8'h00, 11'd1760, 8'd1,  1'b0, 16'h0000, 5'd0,  7'd0,  1'b0},
    '{RD, 8'h00, 11'd80,   8'd1,  1'b0, 16'h0000, 5'd0,  7'd0,  1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;   // cmd
  logic [23:0] s_axis_tdata = '0;     // char_code, read_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // read_data, cursor_row, cursor_col, scrolled
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  logic [15:0]    screen_shadow [CELL_COUNT];
  int             pen_row;
  int             pen_col;
  logic [7:0]     attr_shadow;
  console_reply_t reply_queue [$];
  console_reply_t observed;
  console_reply_t awaited;
  bit             hold_off_armed = 1'b0;
  int             error_count = 0;
  int             scroll_count = 0;
  int             read_count = 0;
  int             write_count = 0;
  int             replies_checked = 0;
  int             idle_cycles = 0;

  text_console_writer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic advance_row();
    pen_col = 0;
    pen_row++;
    if (pen_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
        screen_shadow[i] = screen_shadow[i + COLUMNS];
      end
      for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
        screen_shadow[i] = {attr_shadow, txc_pkg::SPACE_CODE};
      end
      pen_row = ROWS - 1;
      scroll_count++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_reply_t apply_to_screen(input logic cmd, input logic [7:0] code,
                                                     input logic [10:0] index);
    console_reply_t reply;
    reply = '0;
    if (cmd == txc_pkg::CMD_READ) begin
      read_count++;
      if (index < CELL_COUNT) reply.data = screen_shadow[index];
    end else if (code == txc_pkg::NEWLINE_CODE) begin
      write_count++;
      reply.scrolled = advance_row();
    end else begin
      write_count++;
      screen_shadow[pen_row * COLUMNS + pen_col] = {attr_shadow, code};
      pen_col++;
      if (pen_col >= COLUMNS) reply.scrolled = advance_row();
    end
    reply.row = pen_row[4:0];
    reply.col = pen_col[6:0];
    return reply;
  endfunction

  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic cmd, input logic [7:0] code, input logic [10:0] index,
                              input bit typed, input console_reply_t typed_reply, input int gap);
    console_reply_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'b0, index, code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = apply_to_screen(cmd, code, index);
    reply_queue.push_back(typed ? typed_reply : predicted);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_attribute(input logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    attr_shadow = value;
  endtask

  task automatic send_random(input bit quiet);
    logic        cmd;
    logic [7:0]  code;
    logic [10:0] index;
    int          roll;
    roll  = $urandom_range(99);
    code  = 8'($urandom_range(0, 255));
    index = 11'($urandom_range(0, 2047));
    if (roll < 30) begin
      cmd = txc_pkg::CMD_READ;
      if ($urandom_range(99) < 90) index = 11'($urandom_range(0, CELL_COUNT - 1));
    end else begin
      cmd = txc_pkg::CMD_WRITE;
      if (roll < 34) code = txc_pkg::NEWLINE_CODE;
      else if (roll < 80) code = 8'($urandom_range(32, 126));
    end
    send_request(cmd, code, index, 1'b0, '0, pick_gap(quiet));
  endtask

  initial begin
    console_reply_t typed_reply;
    bit             quiet;
    for (int i = 0; i < CELL_COUNT; i++) screen_shadow[i] = '0;
    pen_row     = 0;
    pen_col     = 0;
    attr_shadow = txc_pkg::RESET_ATTR;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      typed_reply = {DIRECTED[r].scrolled, DIRECTED[r].col, DIRECTED[r].row, DIRECTED[r].data};
      for (int k = 0; k < DIRECTED[r].repeats; k++) begin
        send_request(DIRECTED[r].cmd, DIRECTED[r].code, DIRECTED[r].index, DIRECTED[r].typed,
                     typed_reply, pick_gap(1'b0));
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      unique case (p)
        0: set_attribute(8'hFF);
        1: set_attribute(8'h00);
        PHASE_COUNT - 1: set_attribute(txc_pkg::RESET_ATTR);
        default: set_attribute(8'($urandom_range(0, 255)));
      endcase
      if (p == 1) hold_off_armed = 1'b1;
      quiet = 1'b0;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n % 40 == 0) quiet = (p == 1 && n < 80) || ($urandom_range(3) == 0);
        send_random(quiet);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d writes and %0d reads with %0d scrolls over %0d attribute settings.",
             write_count, read_count, scroll_count, PHASE_COUNT + 1);
    $display("Checked %0d replies; %0d mismatches.", replies_checked, error_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int roll;
    int hold_len;
    forever begin
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        m_axis_tready <= 1'b0;
        hold_len = LONG_HOLD;
      end else begin
        roll = $urandom_range(99);
        if (roll < 60) begin
          m_axis_tready <= 1'b1;
          hold_len = $urandom_range(1, 30);
        end else if (roll < 95) begin
          m_axis_tready <= 1'b0;
          hold_len = $urandom_range(1, 3);
        end else begin
          m_axis_tready <= 1'b0;
          hold_len = $urandom_range(10, 60);
        end
      end
      repeat (hold_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      observed = m_axis_tdata[28:0];
      if (reply_queue.size() == 0) begin
        $error("Reply with no request pending: %h", observed);
        error_count++;
      end else begin
        awaited = reply_queue.pop_front();
        replies_checked++;
        if (observed.data != awaited.data) begin
          $error("read_data: expected %h, got %h", awaited.data, observed.data);
          error_count++;
        end
        if (observed.row != awaited.row) begin
          $error("cursor_row: expected %0d, got %0d", awaited.row, observed.row);
          error_count++;
        end
        if (observed.col != awaited.col) begin
          $error("cursor_col: expected %0d, got %0d", awaited.col, observed.col);
          error_count++;
        end
        if (observed.scrolled != awaited.scrolled) begin
          $error("scrolled: expected %0d, got %0d", awaited.scrolled, observed.scrolled);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d replies outstanding.", reply_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
